// ===== src/sodf_pkg.sv =====
// Shared types, constants and register map for the slot occupancy dwell block.
// No dependencies; imported by every module of the block.
package sodf_pkg;

  // Build-time constants
  localparam int NUM_SLOTS          = 64;
  localparam int UNKNOWN_DWELL      = 10;
  localparam int FREE_HEIGHT_MAX_MM = 150;

  // Field widths
  localparam int SLOT_W   = 6;
  localparam int RATIO_W  = 11;
  localparam int HEIGHT_W = 16;
  localparam int OCCH_W   = 15;
  localparam int DWELL_W  = 8;

  // Slot store address width
  localparam int SLOT_AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // Config port
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    ST_UNKNOWN  = 2'd0,
    ST_FREE     = 2'd1,
    ST_OCCUPIED = 2'd2
  } slot_state_e;

  typedef enum logic [2:0] {
    REG_MIN_VIS     = 3'd0,
    REG_OCC_HEIGHT  = 3'd1,
    REG_OCC_ENTER   = 3'd2,
    REG_OCC_EXIT    = 3'd3,
    REG_FREE_MINVIS = 3'd4,
    REG_FREE_MAXSUP = 3'd5,
    REG_OCC_DWELL   = 3'd6,
    REG_FREE_DWELL  = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [RATIO_W-1:0] min_visibility;
    logic [OCCH_W-1:0]  occupied_height_mm;
    logic [RATIO_W-1:0] occupied_enter_support;
    logic [RATIO_W-1:0] occupied_exit_support;
    logic [RATIO_W-1:0] free_min_visibility;
    logic [RATIO_W-1:0] free_max_support;
    logic [DWELL_W-1:0] occupied_dwell;
    logic [DWELL_W-1:0] free_dwell;
  } cfg_t;

  // One entry of the per-slot store; all-zero is the reset value
  typedef struct packed {
    slot_state_e        stable;
    slot_state_e        cand;
    logic [DWELL_W-1:0] dwell;
  } slot_entry_t;

  localparam int ENTRY_W = $bits(slot_entry_t);

endpackage

// ===== src/sodf_in_if.sv =====
// Input sample channel: valid/ready handshake plus the sample fields.
// Depends on sodf_pkg for field widths.
interface sodf_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [sodf_pkg::SLOT_W-1:0]            slot_index;
  logic [sodf_pkg::RATIO_W-1:0]           visibility;
  logic [sodf_pkg::RATIO_W-1:0]           support_ratio;
  logic signed [sodf_pkg::HEIGHT_W-1:0]   max_height_mm;

  modport source (output valid, slot_index, visibility, support_ratio, max_height_mm,
                  input ready);
  modport sink   (input valid, slot_index, visibility, support_ratio, max_height_mm,
                  output ready);
endinterface

// ===== src/sodf_out_if.sv =====
// Result channel: valid/ready handshake plus slot index and debounced status.
// Depends on sodf_pkg for field widths.
interface sodf_out_if;
  logic                        valid;
  logic                        ready;
  logic [sodf_pkg::SLOT_W-1:0] slot_out;
  logic [1:0]                  slot_status;

  modport source (output valid, slot_out, slot_status, input ready);
  modport sink   (input valid, slot_out, slot_status, output ready);
endinterface

// ===== src/slot_occupancy_dwell_fsm_core.sv =====
// Top level of the slot occupancy dwell block: config registers, per-slot
// state memory and the update stage. Depends on sodf_pkg, sodf_in_if,
// sodf_out_if, sodf_cfg, sodf_state_ram, sodf_update.
//
//   port    | dir | handshake            | carries
//   --------+-----+----------------------+------------------------------------------
//   in_i    | in  | valid/ready          | slot_index, visibility, support, height
//   out_o   | out | valid/ready          | slot_out, slot_status
//   APB     | in  | psel/penable/pwrite  | 8 config registers at 4*i, pready tied high
//
// One item per cycle sustained while out_o is not stalled. The accepting edge
// reads the slot entry from the state memory into the update stage; when the
// stage advances, the update runs, writes the entry back and loads the
// output register. Back-to-back items on the same slot see the fresh entry
// through the memory's write-to-read forwarding. Reset clears the per-slot
// valid bits at once, so every slot reads as unknown with a zero count; no
// clearing pass is needed. A stalled output holds the update stage, which
// in turn drops in_i.ready; nothing is lost.
module slot_occupancy_dwell_fsm_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  sodf_in_if.sink                       in_i,
  sodf_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sodf_pkg::PADDR_W-1:0]  paddr,
  input  logic [sodf_pkg::PDATA_W-1:0]  pwdata,
  output logic [sodf_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import sodf_pkg::*;

  cfg_t cfg;

  // Update stage (item whose entry read is in flight / done)
  logic                       s1_valid_q;
  logic [SLOT_W-1:0]          s1_slot_q;
  logic                       s1_ok_q;
  logic [RATIO_W-1:0]         s1_vis_q;
  logic [RATIO_W-1:0]         s1_sup_q;
  logic signed [HEIGHT_W-1:0] s1_h_q;

  // Output register
  logic                       out_valid_q;
  logic [SLOT_W-1:0]          out_slot_q;
  slot_state_e                out_status_q;

  logic                       s1_adv;
  logic                       in_acc;
  logic                       in_ok;
  logic [SLOT_AW-1:0]         in_addr;
  logic [SLOT_AW-1:0]         s1_addr;
  slot_entry_t                cur_entry;
  slot_entry_t                nxt_entry;

  sodf_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Stage advances when the output register is free or being drained
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_acc     = in_i.valid && in_i.ready;

  // Slots beyond the store report unknown and leave state alone
  assign in_ok   = (32'(in_i.slot_index) < NUM_SLOTS);
  assign in_addr = SLOT_AW'(in_i.slot_index);
  assign s1_addr = SLOT_AW'(s1_slot_q);

  sodf_state_ram u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .rd_addr_i (in_addr),
    .rd_data_o (cur_entry),
    .wr_en_i   (s1_adv && s1_ok_q),
    .wr_addr_i (s1_addr),
    .wr_data_i (nxt_entry)
  );

  sodf_update u_update (
    .cfg_i    (cfg),
    .cur_i    (cur_entry),
    .vis_i    (s1_vis_q),
    .sup_i    (s1_sup_q),
    .height_i (s1_h_q),
    .nxt_o    (nxt_entry)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_slot_q <= in_i.slot_index;
      s1_ok_q   <= in_ok;
      s1_vis_q  <= in_i.visibility;
      s1_sup_q  <= in_i.support_ratio;
      s1_h_q    <= in_i.max_height_mm;
    end
    if (s1_adv) begin
      out_slot_q   <= s1_slot_q;
      out_status_q <= s1_ok_q ? nxt_entry.stable : ST_UNKNOWN;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.slot_out    = out_slot_q;
  assign out_o.slot_status = out_status_q;

endmodule

// ===== src/sodf_cfg.sv =====
// APB-style configuration register file for the dwell block.
// Depends on sodf_pkg (register map, cfg_t).
module sodf_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sodf_pkg::PADDR_W-1:0]  paddr,
  input  logic [sodf_pkg::PDATA_W-1:0]  pwdata,
  output logic [sodf_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output sodf_pkg::cfg_t                cfg_o
);
  import sodf_pkg::*;

  cfg_t     cfg_q;
  cfg_reg_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = cfg_reg_e'(paddr[PADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_visibility         <= RATIO_W'(307);
      cfg_q.occupied_height_mm     <= OCCH_W'(300);
      cfg_q.occupied_enter_support <= RATIO_W'(512);
      cfg_q.occupied_exit_support  <= RATIO_W'(307);
      cfg_q.free_min_visibility    <= RATIO_W'(717);
      cfg_q.free_max_support       <= RATIO_W'(102);
      cfg_q.occupied_dwell         <= DWELL_W'(3);
      cfg_q.free_dwell             <= DWELL_W'(5);
    end else if (wr_en) begin
      unique case (idx)
        REG_MIN_VIS:     cfg_q.min_visibility         <= pwdata[RATIO_W-1:0];
        REG_OCC_HEIGHT:  cfg_q.occupied_height_mm     <= pwdata[OCCH_W-1:0];
        REG_OCC_ENTER:   cfg_q.occupied_enter_support <= pwdata[RATIO_W-1:0];
        REG_OCC_EXIT:    cfg_q.occupied_exit_support  <= pwdata[RATIO_W-1:0];
        REG_FREE_MINVIS: cfg_q.free_min_visibility    <= pwdata[RATIO_W-1:0];
        REG_FREE_MAXSUP: cfg_q.free_max_support       <= pwdata[RATIO_W-1:0];
        REG_OCC_DWELL:   cfg_q.occupied_dwell         <= pwdata[DWELL_W-1:0];
        REG_FREE_DWELL:  cfg_q.free_dwell             <= pwdata[DWELL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MIN_VIS:     prdata = PDATA_W'(cfg_q.min_visibility);
      REG_OCC_HEIGHT:  prdata = PDATA_W'(cfg_q.occupied_height_mm);
      REG_OCC_ENTER:   prdata = PDATA_W'(cfg_q.occupied_enter_support);
      REG_OCC_EXIT:    prdata = PDATA_W'(cfg_q.occupied_exit_support);
      REG_FREE_MINVIS: prdata = PDATA_W'(cfg_q.free_min_visibility);
      REG_FREE_MAXSUP: prdata = PDATA_W'(cfg_q.free_max_support);
      REG_OCC_DWELL:   prdata = PDATA_W'(cfg_q.occupied_dwell);
      REG_FREE_DWELL:  prdata = PDATA_W'(cfg_q.free_dwell);
      default:         prdata = '0;
    endcase
  end

endmodule

// ===== src/sodf_state_ram.sv =====
// Per-slot state store: synchronous memory with a registered read, and valid
// bits so unwritten entries read as the reset entry. Depends on sodf_pkg.
module sodf_state_ram (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rd_en_i,
  input  logic [sodf_pkg::SLOT_AW-1:0] rd_addr_i,
  output sodf_pkg::slot_entry_t        rd_data_o,
  input  logic                         wr_en_i,
  input  logic [sodf_pkg::SLOT_AW-1:0] wr_addr_i,
  input  sodf_pkg::slot_entry_t        wr_data_i
);
  import sodf_pkg::*;

  slot_entry_t          mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] vld_q;
  slot_entry_t          rd_q;

  assign rd_data_o = rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  // Same-cycle write to the read address is forwarded
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_q <= wr_data_i;
      end else if (vld_q[rd_addr_i]) begin
        rd_q <= mem[rd_addr_i];
      end else begin
        rd_q <= '0;
      end
    end
  end

endmodule

// ===== src/sodf_update.sv =====
// Sample classification and dwell debounce for one slot entry.
// Depends on sodf_pkg (cfg_t, slot_entry_t, state codes).
module sodf_update (
  input  sodf_pkg::cfg_t                       cfg_i,
  input  sodf_pkg::slot_entry_t                cur_i,
  input  logic [sodf_pkg::RATIO_W-1:0]         vis_i,
  input  logic [sodf_pkg::RATIO_W-1:0]         sup_i,
  input  logic signed [sodf_pkg::HEIGHT_W-1:0] height_i,
  output sodf_pkg::slot_entry_t                nxt_o
);
  import sodf_pkg::*;

  localparam logic signed [HEIGHT_W-1:0] FreeHMax = HEIGHT_W'(FREE_HEIGHT_MAX_MM);

  logic [RATIO_W-1:0]         need;
  logic signed [HEIGHT_W-1:0] occ_h;
  slot_state_e                target;
  logic [DWELL_W-1:0]         cnt;
  logic [DWELL_W-1:0]         dwell_req;
  slot_entry_t                nxt;

  assign occ_h = $signed({1'b0, cfg_i.occupied_height_mm});
  assign need  = (cur_i.stable == ST_OCCUPIED) ? cfg_i.occupied_exit_support
                                               : cfg_i.occupied_enter_support;

  always_comb begin
    if (vis_i < cfg_i.min_visibility) begin
      target = ST_UNKNOWN;
    end else if ((height_i >= occ_h) || (sup_i >= need)) begin
      target = ST_OCCUPIED;
    end else if ((vis_i >= cfg_i.free_min_visibility) &&
                 (sup_i <= cfg_i.free_max_support) && (height_i <= FreeHMax)) begin
      target = ST_FREE;
    end else begin
      target = ST_UNKNOWN;
    end
  end

  always_comb begin
    case (target)
      ST_OCCUPIED: dwell_req = cfg_i.occupied_dwell;
      ST_FREE:     dwell_req = cfg_i.free_dwell;
      default:     dwell_req = DWELL_W'(UNKNOWN_DWELL);
    endcase
  end

  always_comb begin
    nxt = cur_i;
    cnt = cur_i.dwell;
    if (target == cur_i.stable) begin
      nxt.cand  = target;
      nxt.dwell = '0;
    end else begin
      if (cur_i.cand != target) begin
        cnt = DWELL_W'(1);
      end else if (cur_i.dwell != '1) begin
        cnt = cur_i.dwell + DWELL_W'(1);
      end
      nxt.cand  = target;
      nxt.dwell = cnt;
      // candidate held long enough: adopt it
      if (cnt >= dwell_req) begin
        nxt.stable = target;
        nxt.dwell  = '0;
      end
    end
  end

  assign nxt_o = nxt;

endmodule

// ===== src/sodf_chk.sv =====
// Port-level checker for the dwell block, bound to the top level.
// Depends on sodf_pkg for field widths.
module sodf_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [sodf_pkg::SLOT_W-1:0] slot_out,
  input logic [1:0]                  slot_status
);
  import sodf_pkg::*;

  // Input only backs off while the result register is stalled
  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> (out_valid && !out_ready))
    else $error("in ready low without output stall");

  // Status is a legal state code
  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (slot_status == ST_UNKNOWN || slot_status == ST_FREE ||
                   slot_status == ST_OCCUPIED))
    else $error("illegal slot status");

  // An item taken under a stall fills the update stage; a continued stall blocks input
  a_fill_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready && out_valid && !out_ready) ##1 !out_ready |-> !in_ready)
    else $error("input taken while update stage full");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(slot_out) && $stable(slot_status)))
    else $error("stalled result changed");

endmodule

bind slot_occupancy_dwell_fsm_core sodf_chk u_sodf_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (in_i.valid),
  .in_ready    (in_i.ready),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .slot_out    (out_o.slot_out),
  .slot_status (out_o.slot_status)
);
